// File: rtl/fir_pkg.sv
`timescale 1ns / 1ps
// fir_pkg: shared constants, types and codes of the circular fir filter
// used by fir_front, fir_mac and fir_filter_circular; no dependencies
package fir_pkg;

    localparam int TAP_SLOTS    = 32;
    localparam int SAMPLE_WIDTH = 16;
    localparam int COEFF_WIDTH  = 16;
    localparam int FRAC_BITS    = COEFF_WIDTH - 1;
    localparam int TAP_W        = $clog2(TAP_SLOTS);
    localparam int CFG_W        = 6;
    localparam int MODE_W       = 2;
    localparam int PROD_W       = SAMPLE_WIDTH + COEFF_WIDTH;
    localparam int ACC_W        = PROD_W + TAP_W;
    localparam int IN_TDATA_W   = ((SAMPLE_WIDTH + TAP_W + COEFF_WIDTH + 7) / 8) * 8;
    localparam int OUT_TDATA_W  = ((SAMPLE_WIDTH + 7) / 8) * 8;
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [MODE_W-1:0] MODE_FILTER = 2'd0;
    localparam logic [MODE_W-1:0] MODE_COEFF  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

    typedef enum logic [1:0] {
        OP_FILTER,
        OP_COEFF,
        OP_CLEAR
    } fir_op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_FINISH
    } fir_state_t;

    typedef struct packed {
        fir_op_t                  op;
        logic [SAMPLE_WIDTH-1:0]  sample;
        logic [TAP_W-1:0]         index;
        logic [COEFF_WIDTH-1:0]   coeff;
    } fir_cmd_t;

endpackage

// File: rtl/fir_ram.sv
`timescale 1ns / 1ps
// fir_ram: generic single-write, single-read ram with registered read data
// no dependencies
module fir_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/fir_front.sv
`timescale 1ns / 1ps
// fir_front: accepts input words, decodes the mode and queues commands
// depends on fir_pkg
module fir_front (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [fir_pkg::IN_TDATA_W-1:0]   s_axis_tdata,  // sample, coeff_index, coeff_value
    input  logic [fir_pkg::MODE_W-1:0]       s_axis_tuser,  // mode
    output logic                             cmd_valid,
    input  logic                             cmd_ready,
    output fir_pkg::fir_cmd_t                cmd
);
    import fir_pkg::*;

    fir_cmd_t            q_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    fir_cmd_t            dec;
    logic                keep;
    logic                push;
    logic                pop;

    always_comb
    begin
        dec.sample = s_axis_tdata[SAMPLE_WIDTH-1:0];
        dec.index  = s_axis_tdata[SAMPLE_WIDTH +: TAP_W];
        dec.coeff  = s_axis_tdata[SAMPLE_WIDTH+TAP_W +: COEFF_WIDTH];
        dec.op     = OP_FILTER;
        keep       = 1'b1;
        unique case (s_axis_tuser)
            MODE_FILTER: dec.op = OP_FILTER;
            MODE_COEFF:  dec.op = OP_COEFF;
            MODE_CLEAR:  dec.op = OP_CLEAR;
            default:     keep = 1'b0;
        endcase
    end

    assign s_axis_tready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign cmd_valid     = (count_reg != '0);
    assign cmd           = q_reg[rd_ptr_reg];
    assign push          = s_axis_tvalid && s_axis_tready && keep;
    assign pop           = cmd_valid && cmd_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= dec;
        end
    end

endmodule

// File: rtl/fir_mac.sv
`timescale 1ns / 1ps
// fir_mac: executes queued commands; tap store, sample ring and shared mac
// depends on fir_pkg and fir_ram
module fir_mac (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cmd_valid,
    output logic                             cmd_ready,
    input  fir_pkg::fir_cmd_t                cmd,
    input  logic                             cfg_wen,
    input  logic [fir_pkg::CFG_W-1:0]        cfg_wdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [fir_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,  // filtered
    output logic                             m_axis_tuser   // saturated
);
    import fir_pkg::*;

    fir_state_t                state_reg, state_next;
    logic [CFG_W-1:0]          tap_count_reg, tap_count_next;
    logic [TAP_W-1:0]          wp_reg, wp_next;
    logic [TAP_W-1:0]          i_reg, i_next;
    logic [TAP_W-1:0]          pos_reg, pos_next;
    logic [TAP_SLOTS-1:0]      hist_valid_reg, hist_valid_next;
    logic [TAP_SLOTS-1:0]      coeff_valid_reg, coeff_valid_next;
    logic                      rd_v_reg;
    logic                      hv_reg;
    logic                      cv_reg;
    logic                      prod_v_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic                      out_valid_reg, out_valid_next;
    logic [SAMPLE_WIDTH-1:0]   out_data_reg;
    logic                      out_sat_reg;

    logic                      issue;
    logic                      hist_we;
    logic                      coeff_we;
    logic                      acc_clr;
    logic                      out_load;
    logic                      cfg_ok;
    logic [SAMPLE_WIDTH-1:0]   hist_rdata;
    logic [COEFF_WIDTH-1:0]    coeff_rdata;
    logic signed [SAMPLE_WIDTH-1:0] smp;
    logic signed [COEFF_WIDTH-1:0]  cf;
    logic signed [ACC_W-1:0]   rsum;
    logic [ACC_W-FRAC_BITS-SAMPLE_WIDTH:0] top_bits;
    logic                      ovf;
    logic [SAMPLE_WIDTH-1:0]   res_data;

    fir_ram #(
        .WIDTH (SAMPLE_WIDTH),
        .DEPTH (TAP_SLOTS)
    ) u_hist (
        .clk   (clk),
        .we    (hist_we),
        .waddr (wp_reg),
        .wdata (cmd.sample),
        .raddr (pos_reg),
        .rdata (hist_rdata)
    );

    fir_ram #(
        .WIDTH (COEFF_WIDTH),
        .DEPTH (TAP_SLOTS)
    ) u_coeff (
        .clk   (clk),
        .we    (coeff_we),
        .waddr (cmd.index),
        .wdata (cmd.coeff),
        .raddr (i_reg),
        .rdata (coeff_rdata)
    );

    // round half up, floor shift, saturate
    assign rsum     = acc_reg + ACC_W'(1 << (FRAC_BITS - 1));
    assign top_bits = rsum[ACC_W-1:FRAC_BITS+SAMPLE_WIDTH-1];
    assign ovf      = !((&top_bits) || !(|top_bits));
    assign res_data = ovf ? (rsum[ACC_W-1] ? {1'b1, {(SAMPLE_WIDTH-1){1'b0}}}
                                           : {1'b0, {(SAMPLE_WIDTH-1){1'b1}}})
                          : rsum[FRAC_BITS +: SAMPLE_WIDTH];

    assign cfg_ok = cfg_wen && (cfg_wdata != '0) && (cfg_wdata <= CFG_W'(TAP_SLOTS));

    always_comb
    begin
        state_next       = state_reg;
        tap_count_next   = tap_count_reg;
        wp_next          = wp_reg;
        i_next           = i_reg;
        pos_next         = pos_reg;
        hist_valid_next  = hist_valid_reg;
        coeff_valid_next = coeff_valid_reg;
        issue            = 1'b0;
        hist_we          = 1'b0;
        coeff_we         = 1'b0;
        acc_clr          = 1'b0;
        out_load         = 1'b0;
        cmd_ready        = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    unique case (cmd.op)
                        OP_FILTER:
                        begin
                            hist_we                 = 1'b1;
                            hist_valid_next[wp_reg] = 1'b1;
                            i_next                  = '0;
                            pos_next                = wp_reg;
                            acc_clr                 = 1'b1;
                            state_next              = ST_RUN;
                        end
                        OP_COEFF:
                        begin
                            coeff_we                     = 1'b1;
                            coeff_valid_next[cmd.index]  = 1'b1;
                        end
                        OP_CLEAR:
                        begin
                            hist_valid_next = '0;
                            wp_next         = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_RUN:
            begin
                issue = 1'b1;
                if (CFG_W'(i_reg) + 1'b1 == tap_count_reg)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    i_next   = i_reg + 1'b1;
                    pos_next = (pos_reg == '0) ? TAP_W'(tap_count_reg - 1'b1) : pos_reg - 1'b1;
                end
            end
            ST_DRAIN:
            begin
                if (!rd_v_reg && !prod_v_reg)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_load   = 1'b1;
                    wp_next    = (CFG_W'(wp_reg) + 1'b1 == tap_count_reg) ? '0 : wp_reg + 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        if (cfg_ok)
        begin
            tap_count_next  = cfg_wdata;
            hist_valid_next = '0;
            wp_next         = '0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            tap_count_reg   <= CFG_W'(1);
            wp_reg          <= '0;
            i_reg           <= '0;
            pos_reg         <= '0;
            hist_valid_reg  <= '0;
            coeff_valid_reg <= '0;
            rd_v_reg        <= 1'b0;
            prod_v_reg      <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            tap_count_reg   <= tap_count_next;
            wp_reg          <= wp_next;
            i_reg           <= i_next;
            pos_reg         <= pos_next;
            hist_valid_reg  <= hist_valid_next;
            coeff_valid_reg <= coeff_valid_next;
            rd_v_reg        <= issue;
            prod_v_reg      <= rd_v_reg;
            out_valid_reg   <= out_valid_next;
        end
    end

    // entries never written read as zero
    assign smp = hv_reg ? $signed(hist_rdata) : '0;
    assign cf  = cv_reg ? $signed(coeff_rdata) : '0;

    always_ff @(posedge clk)
    begin
        hv_reg <= hist_valid_reg[pos_reg];
        cv_reg <= coeff_valid_reg[i_reg];
        if (rd_v_reg)
        begin
            prod_reg <= smp * cf;
        end
        if (acc_clr)
        begin
            acc_reg <= '0;
        end
        else if (prod_v_reg)
        begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
        if (out_load)
        begin
            out_data_reg <= res_data;
            out_sat_reg  <= ovf;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_TDATA_W'(out_data_reg);
    assign m_axis_tuser  = out_sat_reg;

    a_wp_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        CFG_W'(wp_reg) < tap_count_reg)
        else $error("write position outside tap count");

    a_tap_count_legal: assert property (@(posedge clk) disable iff (!rst_n)
        (tap_count_reg != '0) && (tap_count_reg <= CFG_W'(TAP_SLOTS)))
        else $error("tap count out of range");

    a_finish_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH) |-> (!rd_v_reg && !prod_v_reg))
        else $error("result formed before mac pipeline drained");

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (m_axis_tvalid && (state_reg == ST_IDLE)))
        else $error("result load did not raise output valid");

endmodule

// File: rtl/fir_filter_circular.sv
`timescale 1ns / 1ps
// fir_filter_circular: top level of the programmable-length circular fir filter
// depends on fir_pkg, fir_front, fir_mac (and fir_ram through fir_mac)
//
// input stream: s_axis_tuser carries the mode (filter sample, write coefficient,
// clear history); tdata carries sample, coeff_index and coeff_value. a mode 3
// word is accepted and dropped. words go through a two-entry command queue, so
// the input keeps accepting while the mac engine works.
// output stream: one word per filter sample, tdata = rounded and saturated
// result, tuser = saturation flag. the result sits in an output register; a
// stalled receiver holds it, the engine waits in its final state, and once the
// queue fills, s_axis_tready drops.
// cfg_wen / cfg_wdata write tap_count (1..32, other values ignored); a write
// clears the sample history and write position.
// a filter sample occupies the mac engine while one shared multiplier walks
// the taps, with one read of each ram per tap, then a three-stage drain and
// a round/saturate state. coefficient and clear words are handled in the idle
// state.
// reset clears history, coefficients, position and sets tap_count to 1 at once
// through per-entry valid bits; no clearing pass is needed.
module fir_filter_circular (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [fir_pkg::IN_TDATA_W-1:0]   s_axis_tdata,  // sample, coeff_index, coeff_value
    input  logic [fir_pkg::MODE_W-1:0]       s_axis_tuser,  // mode
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [fir_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,  // filtered
    output logic                             m_axis_tuser,  // saturated
    input  logic                             cfg_wen,
    input  logic [fir_pkg::CFG_W-1:0]        cfg_wdata
);
    import fir_pkg::*;

    logic      cmd_valid;
    logic      cmd_ready;
    fir_cmd_t  cmd;

    fir_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .cmd_valid     (cmd_valid),
        .cmd_ready     (cmd_ready),
        .cmd           (cmd)
    );

    fir_mac u_mac (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_valid     (cmd_valid),
        .cmd_ready     (cmd_ready),
        .cmd           (cmd),
        .cfg_wen       (cfg_wen),
        .cfg_wdata     (cfg_wdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule
